// ----- design/swmi_pkg.sv -----
// ----------------------------------------------------------------------------
// swmi_pkg: shared types and constants of the sliding window maximum unit
// Window depth, derived widths and the control group passed to the search.
// ----------------------------------------------------------------------------
package swmi_pkg;

	localparam int MAX_WINDOW = 64;

	localparam int SAMPLE_W = 32;
	localparam int POS_W    = 32;
	localparam int WL_W     = 7;

	// Width that holds the clamped window length 1..MAX_WINDOW.
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int KC_W  = (CNT_W > WL_W) ? CNT_W : WL_W;

	// The search looks at the cells in groups of eight.
	localparam int GRP_SIZE = 8;
	localparam int SUB_W    = 3;
	localparam int NUM_GRP  = (MAX_WINDOW + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GRP_W    = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
	localparam int PAD_W    = NUM_GRP * GRP_SIZE;
	localparam int IDX_W    = GRP_W + SUB_W;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
	} swmi_ctrl_t;

endpackage

// ----- design/swmi_cell.sv -----
// ----------------------------------------------------------------------------
// swmi_cell: one age slot of the candidate shift line
// Holds one sample and whether it is still a candidate for the maximum.
// ----------------------------------------------------------------------------
module swmi_cell
	import swmi_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift_en,
	input  logic                       entry,
	input  logic                       clear,
	input  logic                       keep,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       in_alive,
	input  logic signed [SAMPLE_W-1:0] in_value,
	output logic                       alive,
	output logic signed [SAMPLE_W-1:0] value
);

	logic                       alive_q;
	logic signed [SAMPLE_W-1:0] value_q;
	logic                       alive_d;

	// A neighbor's entry survives the move only if it is inside the window
	// and strictly larger than the newest sample.
	always_comb begin
		if (entry) begin
			alive_d = 1'b1;
		end else begin
			alive_d = in_alive && keep && !clear && (in_value > sample);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
		end else if (shift_en) begin
			alive_q <= alive_d;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			value_q <= in_value;
		end
	end

	assign alive = alive_q;
	assign value = value_q;

endmodule

// ----- design/swmi_search.sv -----
// ----------------------------------------------------------------------------
// swmi_search: oldest live candidate search
// Two registered levels: a priority pick inside each group of eight cells,
// then the oldest group, turned into a position.
// ----------------------------------------------------------------------------
module swmi_search
	import swmi_pkg::*;
(
	input  logic                  clk,
	input  swmi_ctrl_t            ctrl,
	input  logic [MAX_WINDOW-1:0] alive,
	input  logic [POS_W-1:0]      pos_s0,
	output logic [POS_W-1:0]      max_position
);

	logic [PAD_W-1:0]   flags;
	logic [NUM_GRP-1:0] any_d;
	logic [SUB_W-1:0]   sub_d [NUM_GRP];

	logic [NUM_GRP-1:0] any_s1;
	logic [SUB_W-1:0]   sub_s1 [NUM_GRP];
	logic [POS_W-1:0]   pos_s1;

	logic [GRP_W-1:0]   grp_sel;
	logic [SUB_W-1:0]   sub_sel;
	logic [IDX_W-1:0]   age;
	logic [POS_W-1:0]   max_position_q;

	assign flags = PAD_W'(alive);

	// Highest cell index is the oldest live entry.
	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			any_d[g] = |flags[g*GRP_SIZE +: GRP_SIZE];
			sub_d[g] = '0;
			for (int s = 0; s < GRP_SIZE; s++) begin
				if (flags[g*GRP_SIZE + s]) begin
					sub_d[g] = SUB_W'(s);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s1) begin
			any_s1 <= any_d;
			sub_s1 <= sub_d;
			pos_s1 <= pos_s0;
		end
	end

	always_comb begin
		grp_sel = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			if (any_s1[g]) begin
				grp_sel = GRP_W'(g);
			end
		end
		sub_sel = sub_s1[grp_sel];
		age     = {grp_sel, sub_sel};
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s2) begin
			max_position_q <= pos_s1 - POS_W'(age);
		end
	end

	assign max_position = max_position_q;

endmodule

// ----- design/sliding_window_max_index_unit.sv -----
// ----------------------------------------------------------------------------
// sliding_window_max_index_unit: position of the maximum over a sliding window
// Top level: handshake, window register, cell chain and position counter.
// ----------------------------------------------------------------------------
// The unit takes one signed sample per cycle while s_axis_tready is high and
// returns, for each one, the position of the largest of the last window_length
// samples (newest wins on ties). A row of MAX_WINDOW cells, one per sample
// age, shifts every accepted sample along and drops entries that are too old
// or not above the newest sample, all in the cycle of acceptance; that update
// of the cell row sets the rate of one sample per cycle. After acceptance, the
// result beat passes through the two registered levels of the search, the
// second of which is the output register, and is taken when the result side
// is ready. tuser[0] high starts a new sequence at position 0.
// Window lengths of zero act as one, lengths above MAX_WINDOW as MAX_WINDOW.
// No clearing pass is needed after reset.
module sliding_window_max_index_unit
	import swmi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [WL_W-1:0]   cfg_wdata,      // window_length
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [31:0]       s_axis_tdata,   // [31:0] sample
	input  logic [0:0]        s_axis_tuser,   // [0] first
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [31:0]       m_axis_tdata    // [31:0] max_position
);

	logic [WL_W-1:0]  wl_q;
	logic [KC_W-1:0]  wl_ext;
	logic [KC_W-1:0]  k_eff;

	logic [POS_W-1:0] next_pos_q;
	logic [POS_W-1:0] pos_s0;
	logic [POS_W-1:0] pos_cur;
	logic             v_s0_q;
	logic             v_s1_q;
	logic             m_valid_q;

	logic             accept;
	logic             first;
	swmi_ctrl_t       ctrl;

	logic signed [SAMPLE_W-1:0] sample;
	logic [MAX_WINDOW-1:0]      alive_w;
	logic signed [SAMPLE_W-1:0] value_w [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]      keep_w;

	assign sample = $signed(s_axis_tdata[SAMPLE_W-1:0]);
	assign first  = s_axis_tuser[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= WL_W'(1);
		end else if (cfg_we) begin
			wl_q <= cfg_wdata;
		end
	end

	always_comb begin
		wl_ext = KC_W'(wl_q);
		if (wl_ext == '0) begin
			k_eff = KC_W'(1);
		end else if (wl_ext > KC_W'(MAX_WINDOW)) begin
			k_eff = KC_W'(MAX_WINDOW);
		end else begin
			k_eff = wl_ext;
		end
	end

	// Each stage moves when the one after it is free or moving.
	assign ctrl.ld_s2    = !m_valid_q || m_axis_tready;
	assign ctrl.ld_s1    = !v_s1_q || ctrl.ld_s2;
	assign s_axis_tready = !v_s0_q || ctrl.ld_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign pos_cur = first ? '0 : next_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_pos_q <= '0;
			v_s0_q     <= 1'b0;
			v_s1_q     <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				next_pos_q <= pos_cur + POS_W'(1);
				v_s0_q     <= 1'b1;
			end else if (ctrl.ld_s1) begin
				v_s0_q <= 1'b0;
			end
			if (ctrl.ld_s1) begin
				v_s1_q <= v_s0_q;
			end
			if (ctrl.ld_s2) begin
				m_valid_q <= v_s1_q;
			end
		end
	end

	// Position of the newest sample held in cell zero.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s0 <= pos_cur;
		end
	end

	for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
		// An entry landing in cell j is j samples old.
		assign keep_w[j] = KC_W'(j) < k_eff;

		if (j == 0) begin : g_head
			swmi_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (accept),
				.entry    (1'b1),
				.clear    (first),
				.keep     (keep_w[j]),
				.sample   (sample),
				.in_alive (1'b1),
				.in_value (sample),
				.alive    (alive_w[j]),
				.value    (value_w[j])
			);
		end else begin : g_body
			swmi_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (accept),
				.entry    (1'b0),
				.clear    (first),
				.keep     (keep_w[j]),
				.sample   (sample),
				.in_alive (alive_w[j-1]),
				.in_value (value_w[j-1]),
				.alive    (alive_w[j]),
				.value    (value_w[j])
			);
		end
	end

	swmi_search u_search (
		.clk          (clk),
		.ctrl         (ctrl),
		.alive        (alive_w),
		.pos_s0       (pos_s0),
		.max_position (m_axis_tdata)
	);

	assign m_axis_tvalid = m_valid_q;

endmodule

// ----- tb/tb_sliding_window_max_index_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_max_index_unit: self-checking bench of the window maximum
// A short table of directed samples, then phases of random sample shapes under
// several window lengths, with random idle gaps on both streams. Every result
// beat is checked against the table's position or a local predictor of the queue.
// ----------------------------------------------------------------------------
module tb_sliding_window_max_index_unit;
	import swmi_pkg::*;

	localparam int        RANDOM_ITEMS = 600;
	localparam int        DRAIN_CYCLES = 8;
	localparam int        HOLD_CYCLES  = 300;
	localparam int        IDLE_LIMIT   = 3000;
	localparam logic [7:0] KEEP_WINDOW = 8'hFF;

	typedef enum int {
		SHAPE_RANDOM,
		SHAPE_TIES,
		SHAPE_FALLING,
		SHAPE_RISING,
		SHAPE_NOISE
	} sample_shape_t;

	typedef struct packed {
		logic [7:0]  window;    // KEEP_WINDOW leaves the register as it is
		logic [31:0] sample;
		logic        first;
		logic        typed;     // position below is the expected answer
		logic [31:0] position;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 21;
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		// Reset window length is one, positions start at zero without a first.
		'{KEEP_WINDOW, 32'd5,        1'b0, 1'b1, 32'd0},
		'{KEEP_WINDOW, 32'hFFFFFFFB, 1'b0, 1'b1, 32'd1},
		'{KEEP_WINDOW, 32'h7FFFFFFF, 1'b0, 1'b1, 32'd2},
		// A zero window acts as one.
		'{8'd0,        32'h80000000, 1'b1, 1'b1, 32'd0},
		'{KEEP_WINDOW, 32'h7FFFFFFF, 1'b0, 1'b1, 32'd1},
		'{KEEP_WINDOW, 32'h80000000, 1'b0, 1'b1, 32'd2},
		// The largest register value is clamped to the full depth; ties go newest.
		'{8'd127,      32'h80000000, 1'b1, 1'b1, 32'd0},
		'{KEEP_WINDOW, 32'h80000000, 1'b0, 1'b1, 32'd1},
		'{KEEP_WINDOW, 32'h7FFFFFFF, 1'b0, 1'b1, 32'd2},
		'{KEEP_WINDOW, 32'h00000000, 1'b0, 1'b1, 32'd2},
		'{KEEP_WINDOW, 32'h7FFFFFFF, 1'b0, 1'b1, 32'd4},
		// Old maxima age out of a short window.
		'{8'd3,        32'd10,       1'b1, 1'b1, 32'd0},
		'{KEEP_WINDOW, 32'd3,        1'b0, 1'b1, 32'd0},
		'{KEEP_WINDOW, 32'd2,        1'b0, 1'b1, 32'd0},
		'{KEEP_WINDOW, 32'd1,        1'b0, 1'b1, 32'd1},
		'{KEEP_WINDOW, 32'hFFFFFFFF, 1'b0, 1'b0, 32'd0},
		// Window shortened in the middle of a sequence.
		'{8'd64,       32'd100,      1'b1, 1'b1, 32'd0},
		'{KEEP_WINDOW, 32'd1,        1'b0, 1'b1, 32'd0},
		'{KEEP_WINDOW, 32'd2,        1'b0, 1'b1, 32'd0},
		'{8'd2,        32'hFFFFFFFD, 1'b0, 1'b0, 32'd0},
		'{KEEP_WINDOW, 32'hFFFFFFFE, 1'b0, 1'b0, 32'd0}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [WL_W-1:0]   cfg_wdata;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata;   // [31:0] sample
	logic [0:0]        s_axis_tuser;   // [0] first
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [31:0]       m_axis_tdata;   // [31:0] max_position

	// Predictor state: candidate queue, oldest at the head.
	logic [31:0]        held_pos [MAX_WINDOW];
	logic signed [31:0] held_val [MAX_WINDOW];
	int                 held_count;
	int                 held_head;
	logic [31:0]        pos_counter;
	logic [WL_W-1:0]    window_setting;

	logic [31:0] expected_positions [$];
	logic [31:0] oldest_position;
	int          mismatches;
	int          idle_cycles;
	bit          tx_gaps;
	bit          rx_gaps;
	bit          hold_off_request;

	sliding_window_max_index_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Pushes one sample into the candidate queue and returns the position
	// of the window maximum.
	function automatic logic [31:0] advance_window_max(logic signed [31:0] value, logic first);
		logic [31:0] k;
		logic [31:0] pos;
		k = 32'(window_setting);
		if (k < 1)
			k = 1;
		if (k > MAX_WINDOW)
			k = MAX_WINDOW;
		if (first) begin
			held_count  = 0;
			held_head   = 0;
			pos_counter = '0;
		end
		pos = pos_counter;
		while (held_count > 0 && value >= held_val[(held_head + held_count - 1) % MAX_WINDOW])
			held_count--;
		// A full queue only holds a head that is already out of any window.
		if (held_count >= MAX_WINDOW) begin
			held_head = (held_head + 1) % MAX_WINDOW;
			held_count--;
		end
		held_pos[(held_head + held_count) % MAX_WINDOW] = pos;
		held_val[(held_head + held_count) % MAX_WINDOW] = value;
		held_count++;
		while (held_count > 1 && 32'(pos - held_pos[held_head]) >= k) begin
			held_head = (held_head + 1) % MAX_WINDOW;
			held_count--;
		end
		pos_counter = pos + 32'd1;
		return held_pos[held_head];
	endfunction

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_sample(input logic [31:0] value, input logic first, input logic typed,
			input logic [31:0] typed_pos);
		int          gap;
		logic [31:0] predicted;
		gap = (tx_gaps && $urandom_range(0, 2) == 0) ? idle_length() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= first;
		do @(posedge clk); while (!s_axis_tready);
		predicted = advance_window_max(value, first);
		expected_positions = {expected_positions, (typed ? typed_pos : predicted)};
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_positions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_window(input logic [WL_W-1:0] length);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= length;
		@(posedge clk);
		cfg_we    <= 1'b0;
		window_setting = length;
	endtask

	// Result side: random back-pressure and one long hold-off on request.
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_request = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat (idle_length()) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_positions.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %0d",
					$time, m_axis_tdata);
				mismatches++;
			end else begin
				oldest_position = expected_positions[0];
				expected_positions.delete(0);
				if (m_axis_tdata !== oldest_position) begin
					$display("%0t: max_position mismatch, expected %0d, actual %0d",
						$time, oldest_position, m_axis_tdata);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int            phase;
		int            remaining;
		int            run_len;
		int            items_sent;
		sample_shape_t shape;
		logic [31:0]   value;
		logic          first;
		logic [6:0]    length;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		s_axis_tvalid    = 1'b0;
		s_axis_tdata     = '0;
		s_axis_tuser     = '0;
		mismatches       = 0;
		idle_cycles      = 0;
		tx_gaps          = 1'b1;
		rx_gaps          = 1'b1;
		hold_off_request = 1'b0;
		held_count       = 0;
		held_head        = 0;
		pos_counter      = '0;
		window_setting   = 7'd1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED[i].window != KEEP_WINDOW)
				load_window(DIRECTED[i].window[6:0]);
			send_sample(DIRECTED[i].sample, DIRECTED[i].first, DIRECTED[i].typed,
				DIRECTED[i].position);
		end

		// Early phases pin the extreme window settings: the first one runs a long
		// falling sequence so that the queue fills, the third one holds off the
		// result side so that the input stalls.
		items_sent = 0;
		phase      = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case (phase)
				0:       length = 7'd64;
				1:       length = 7'd0;
				2:       length = 7'd127;
				3:       length = 7'd1;
				4:       length = 7'd2;
				default: length = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(65, 127))
					: 7'($urandom_range(1, 64));
			endcase
			load_window(length);
			tx_gaps   = ($urandom_range(0, 2) != 0);
			rx_gaps   = ($urandom_range(0, 2) != 0);
			remaining = (phase == 0) ? 100 : $urandom_range(40, 80);
			if (phase == 2) begin
				tx_gaps          = 1'b0;
				hold_off_request = 1'b1;
			end
			first = (phase == 0) || ($urandom_range(0, 3) != 0);
			while (remaining > 0) begin
				if (phase == 0) begin
					shape   = SHAPE_FALLING;
					run_len = remaining;
				end else begin
					shape   = sample_shape_t'($urandom_range(0, 4));
					run_len = $urandom_range(5, 40);
					if (run_len > remaining)
						run_len = remaining;
				end
				value = (shape == SHAPE_FALLING) ? $urandom_range(0, 32'h3FFFFFFF) : $urandom;
				repeat (run_len) begin
					case (shape)
						SHAPE_TIES:    value = 32'($urandom_range(0, 8)) - 32'd4;
						SHAPE_FALLING: value = value - 32'($urandom_range(1, 1000));
						SHAPE_RISING:  value = value + 32'($urandom_range(1, 1000));
						SHAPE_NOISE: begin
							value = $urandom;
							first = first | ($urandom_range(0, 3) == 0);
						end
						default:       value = $urandom;
					endcase
					send_sample(value, first, 1'b0, '0);
					first = (phase != 0) && ($urandom_range(0, 59) == 0);
					items_sent++;
					remaining--;
				end
			end
			phase++;
		end

		drain_results();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
